>>> hdl/cpeb_pkg.sv
// Shared widths, payload type and helper functions for the circle pair bounce pipeline.
package cpeb_pkg;

	localparam int POS_W     = 20;
	localparam int VEL_W     = 16;
	localparam int RAD_W     = 16;
	// signed centre difference before range check
	localparam int DIFF_W    = POS_W + 1;
	// centre differences beyond this never touch
	localparam int NEAR_LIM  = 2 ** (RAD_W + 1);
	localparam int MAG_W     = RAD_W + 2;
	localparam int DVD_W     = MAG_W + 1;
	localparam int DV_W      = VEL_W + 1;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int DD_W      = SQ_W + 1;
	localparam int RS_W      = RAD_W + 1;
	localparam int RS2_W     = 2 * RS_W;
	localparam int PROD_W    = DV_W + DVD_W;
	localparam int DOT_W     = PROD_W + 1;
	localparam int NUM_W     = DOT_W + MAG_W;
	// remainder holds twice the numerator
	localparam int REM_W     = NUM_W + 1;
	// quotient bits of 2*N/dd, one per divider stage
	localparam int QB        = MAG_W + 1;
	localparam int T_W       = QB + 1;
	localparam int SUM_W     = T_W + 1;

	typedef struct packed {
		logic signed [VEL_W-1:0] v1x;
		logic signed [VEL_W-1:0] v1y;
		logic signed [VEL_W-1:0] v2x;
		logic signed [VEL_W-1:0] v2y;
		logic                    touch;
		logic                    same;
		logic                    neg_x;
		logic                    neg_y;
	} pay_t;

	// Clamp a widened sum to the velocity range.
	function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] vmax;
		logic signed [SUM_W-1:0] vmin;
		vmax = SUM_W'((2 ** (VEL_W - 1)) - 1);
		vmin = -vmax - SUM_W'(1);
		if (s > vmax) return vmax[VEL_W-1:0];
		if (s < vmin) return vmin[VEL_W-1:0];
		return s[VEL_W-1:0];
	endfunction

	// Apply a rounded transfer to one velocity component.
	function automatic logic signed [VEL_W-1:0] apply_t(
		input logic signed [VEL_W-1:0] v,
		input logic [QB-1:0]           q2,
		input logic                    neg,
		input logic                    sub
	);
		logic [QB:0]             qr;
		logic signed [T_W-1:0]   t;
		logic signed [SUM_W-1:0] s;
		qr = ({1'b0, q2} + (QB+1)'(1)) >> 1;
		t  = (neg ^ sub) ? -$signed(T_W'(qr)) : $signed(T_W'(qr));
		s  = SUM_W'(v) + SUM_W'(t);
		return sat_vel(s);
	endfunction

endpackage

>>> hdl/circle_pair_elastic_bounce.sv
// Equal-mass elastic bounce of two circles: contact test, transfer divide, saturation.
// The pipeline has 5 arithmetic stages, 19 divider stages at one quotient bit each,
// and one rounding and saturation stage between input request and result.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
module circle_pair_elastic_bounce import cpeb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [POS_W-1:0]        first_pos_x,
	input  logic [POS_W-1:0]        first_pos_y,
	input  logic [RAD_W-1:0]        first_radius,
	input  logic signed [VEL_W-1:0] first_vel_x,
	input  logic signed [VEL_W-1:0] first_vel_y,
	input  logic [POS_W-1:0]        second_pos_x,
	input  logic [POS_W-1:0]        second_pos_y,
	input  logic [RAD_W-1:0]        second_radius,
	input  logic signed [VEL_W-1:0] second_vel_x,
	input  logic signed [VEL_W-1:0] second_vel_y,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    contact,
	output logic                    coincident,
	output logic signed [VEL_W-1:0] new_first_vel_x,
	output logic signed [VEL_W-1:0] new_first_vel_y,
	output logic signed [VEL_W-1:0] new_second_vel_x,
	output logic signed [VEL_W-1:0] new_second_vel_y
);

	logic en;

	// advance every stage unless the output holds a result that is not taken
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: centre differences, range check, radius sum, velocity differences
	logic signed [DIFF_W-1:0] dx_full, dy_full;
	logic [DIFF_W-1:0]        adx_full, ady_full;

	assign dx_full  = $signed({1'b0, second_pos_x}) - $signed({1'b0, first_pos_x});
	assign dy_full  = $signed({1'b0, second_pos_y}) - $signed({1'b0, first_pos_y});
	assign adx_full = dx_full[DIFF_W-1] ? DIFF_W'(-dx_full) : DIFF_W'(dx_full);
	assign ady_full = dy_full[DIFF_W-1] ? DIFF_W'(-dy_full) : DIFF_W'(dy_full);

	logic                    v_s1;
	logic signed [DVD_W-1:0] dx_s1, dy_s1;
	logic [MAG_W-1:0]        adx_s1, ady_s1;
	logic                    near_s1;
	logic [RS_W-1:0]         rs_s1;
	logic signed [DV_W-1:0]  dvx_s1, dvy_s1;
	pay_t                    p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= dx_full[DVD_W-1:0];
			dy_s1   <= dy_full[DVD_W-1:0];
			adx_s1  <= adx_full[MAG_W-1:0];
			ady_s1  <= ady_full[MAG_W-1:0];
			near_s1 <= (adx_full <= DIFF_W'(NEAR_LIM)) && (ady_full <= DIFF_W'(NEAR_LIM));
			rs_s1   <= RS_W'(first_radius) + RS_W'(second_radius);
			dvx_s1  <= DV_W'(second_vel_x) - DV_W'(first_vel_x);
			dvy_s1  <= DV_W'(second_vel_y) - DV_W'(first_vel_y);
			p_s1    <= '{v1x: first_vel_x, v1y: first_vel_y, v2x: second_vel_x,
				v2y: second_vel_y, touch: 1'b0, same: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
		end
	end

	// stage 2: squares and dot product terms
	logic                     v_s2;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2;
	logic [RS2_W-1:0]         rs2_s2;
	logic signed [PROD_W-1:0] px_s2, py_s2;
	logic [MAG_W-1:0]         adx_s2, ady_s2;
	logic                     sdx_s2, sdy_s2, near_s2;
	pay_t                     p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2  <= SQ_W'(adx_s1) * SQ_W'(adx_s1);
			sqy_s2  <= SQ_W'(ady_s1) * SQ_W'(ady_s1);
			rs2_s2  <= RS2_W'(rs_s1) * RS2_W'(rs_s1);
			px_s2   <= PROD_W'(dvx_s1) * PROD_W'(dx_s1);
			py_s2   <= PROD_W'(dvy_s1) * PROD_W'(dy_s1);
			adx_s2  <= adx_s1;
			ady_s2  <= ady_s1;
			sdx_s2  <= dx_s1[DVD_W-1];
			sdy_s2  <= dy_s1[DVD_W-1];
			near_s2 <= near_s1;
			p_s2    <= p_s1;
		end
	end

	// stage 3: squared distance, dot product, contact test
	logic [DD_W-1:0]         dd_sum;
	logic                    v_s3;
	logic [DD_W-1:0]         dd_s3;
	logic signed [DOT_W-1:0] dot_s3;
	logic [MAG_W-1:0]        adx_s3, ady_s3;
	logic                    sdx_s3, sdy_s3;
	pay_t                    p_s3;

	assign dd_sum = DD_W'(sqx_s2) + DD_W'(sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dd_s3        <= dd_sum;
			dot_s3       <= DOT_W'(px_s2) + DOT_W'(py_s2);
			adx_s3       <= adx_s2;
			ady_s3       <= ady_s2;
			sdx_s3       <= sdx_s2;
			sdy_s3       <= sdy_s2;
			p_s3         <= '{v1x: p_s2.v1x, v1y: p_s2.v1y, v2x: p_s2.v2x, v2y: p_s2.v2y,
				touch: near_s2 && (dd_sum <= DD_W'(rs2_s2)),
				same: near_s2 && (dd_sum == '0),
				neg_x: p_s2.neg_x, neg_y: p_s2.neg_y};
		end
	end

	// stage 4: dot magnitude and transfer signs
	logic                v_s4;
	logic [DOT_W-1:0]    m_s4;
	logic [DD_W-1:0]     dd_s4;
	logic [MAG_W-1:0]    adx_s4, ady_s4;
	pay_t                p_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4       <= dot_s3[DOT_W-1] ? DOT_W'(-dot_s3) : DOT_W'(dot_s3);
			dd_s4      <= dd_s3;
			adx_s4     <= adx_s3;
			ady_s4     <= ady_s3;
			p_s4       <= '{v1x: p_s3.v1x, v1y: p_s3.v1y, v2x: p_s3.v2x, v2y: p_s3.v2y,
				touch: p_s3.touch, same: p_s3.same,
				neg_x: dot_s3[DOT_W-1] ^ sdx_s3,
				neg_y: dot_s3[DOT_W-1] ^ sdy_s3};
		end
	end

	// stage 5: numerators |dot| * |d_k|
	logic             v_s5;
	logic [NUM_W-1:0] nx_s5, ny_s5;
	logic [DD_W-1:0]  dd_s5;
	pay_t             p_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s5 <= NUM_W'(m_s4) * NUM_W'(adx_s4);
			ny_s5 <= NUM_W'(m_s4) * NUM_W'(ady_s4);
			dd_s5 <= dd_s4;
			p_s5  <= p_s4;
		end
	end

	// divider stages: restoring division of 2*N by dd, one quotient bit per stage
	logic             vld_sd [QB];
	logic [REM_W-1:0] remx_sd [QB];
	logic [REM_W-1:0] remy_sd [QB];
	logic [QB-1:0]    qx_sd [QB];
	logic [QB-1:0]    qy_sd [QB];
	logic [DD_W-1:0]  dd_sd [QB];
	pay_t             p_sd [QB];

	for (genvar i = 0; i < QB; i++) begin : g_div
		localparam int K = QB - 1 - i;
		logic             vin;
		logic [REM_W-1:0] rxin, ryin;
		logic [QB-1:0]    qxin, qyin;
		logic [DD_W-1:0]  ddin;
		pay_t             pin;
		logic [REM_W:0]   dsh, trx, try_;

		if (i == 0) begin : g_first
			assign vin  = v_s5;
			assign rxin = {nx_s5, 1'b0};
			assign ryin = {ny_s5, 1'b0};
			assign qxin = '0;
			assign qyin = '0;
			assign ddin = dd_s5;
			assign pin  = p_s5;
		end else begin : g_next
			assign vin  = vld_sd[i-1];
			assign rxin = remx_sd[i-1];
			assign ryin = remy_sd[i-1];
			assign qxin = qx_sd[i-1];
			assign qyin = qy_sd[i-1];
			assign ddin = dd_sd[i-1];
			assign pin  = p_sd[i-1];
		end

		assign dsh  = (REM_W+1)'(ddin) << K;
		assign trx  = {1'b0, rxin} - dsh;
		assign try_ = {1'b0, ryin} - dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[i] <= 1'b0;
			end else if (en) begin
				vld_sd[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				remx_sd[i] <= trx[REM_W] ? rxin : trx[REM_W-1:0];
				remy_sd[i] <= try_[REM_W] ? ryin : try_[REM_W-1:0];
				qx_sd[i]   <= {qxin[QB-2:0], !trx[REM_W]};
				qy_sd[i]   <= {qyin[QB-2:0], !try_[REM_W]};
				dd_sd[i]   <= ddin;
				p_sd[i]    <= pin;
			end
		end
	end

	// output stage: round, apply transfer, saturate; pass through without a bounce
	pay_t pf;
	logic bounce;

	assign pf     = p_sd[QB-1];
	assign bounce = pf.touch && !pf.same;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_sd[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			contact    <= pf.touch;
			coincident <= pf.same;
			if (bounce) begin
				new_first_vel_x  <= apply_t(pf.v1x, qx_sd[QB-1], pf.neg_x, 1'b0);
				new_first_vel_y  <= apply_t(pf.v1y, qy_sd[QB-1], pf.neg_y, 1'b0);
				new_second_vel_x <= apply_t(pf.v2x, qx_sd[QB-1], pf.neg_x, 1'b1);
				new_second_vel_y <= apply_t(pf.v2y, qy_sd[QB-1], pf.neg_y, 1'b1);
			end else begin
				new_first_vel_x  <= pf.v1x;
				new_first_vel_y  <= pf.v1y;
				new_second_vel_x <= pf.v2x;
				new_second_vel_y <= pf.v2y;
			end
		end
	end

	// coincident centres always count as contact
	a_same_touch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!coincident || contact))
		else $error("coincident without contact");

	// a waiting result holds through a stall
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(new_first_vel_x)
			&& $stable(new_second_vel_y) && $stable(contact)))
		else $error("result changed while stalled");

	// a stalled pipeline takes no new request
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("request taken during stall");

	// contact flags are set only for centres in range; at stage 4 coincident implies contact
	a_near: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && p_s4.same) |-> p_s4.touch)
		else $error("coincident flag without contact in pipeline");

endmodule

>>> dv/circle_pair_elastic_bounce_tb.sv
// Self-checking testbench for the circle pair elastic bounce pipeline.
module circle_pair_elastic_bounce_tb;
	import cpeb_pkg::*;

	typedef struct {
		logic [POS_W-1:0]        x1, y1;
		logic [RAD_W-1:0]        r1;
		logic signed [VEL_W-1:0] v1x, v1y;
		logic [POS_W-1:0]        x2, y2;
		logic [RAD_W-1:0]        r2;
		logic signed [VEL_W-1:0] v2x, v2y;
	} pair_t;

	typedef struct {
		logic                    touch;
		logic                    same;
		logic signed [VEL_W-1:0] n1x, n1y, n2x, n2y;
	} bounce_t;

	// Bounce predictor and queue of pending bounce results.
	class bounce_board;
		bounce_t pending[$];
		int      errors;

		function new();
			errors = 0;
		endfunction

		// round(dot * dk / dd), ties away from zero
		function longint along_share(longint dot, longint dk, longint unsigned dd);
			longint unsigned m, a, whole, part, q, rem;
			m = (dot < 0) ? -dot : dot;
			a = (dk < 0) ? -dk : dk;
			whole = m / dd;
			part = (m % dd) * a;
			q = whole * a + part / dd;
			rem = part % dd;
			if (2 * rem >= dd) q++;
			return ((dot < 0) != (dk < 0)) ? -longint'(q) : longint'(q);
		endfunction

		function logic signed [VEL_W-1:0] clip(longint v);
			if (v > 32767) return 16'sh7fff;
			if (v < -32768) return 16'sh8000;
			return v[VEL_W-1:0];
		endfunction

		// Note an accepted request and queue its predicted bounce.
		function void note(pair_t p);
			bounce_t e;
			longint dx, dy, adx, ady, rs, dot, tx, ty;
			longint unsigned dd;
			dx = longint'(p.x2) - longint'(p.x1);
			dy = longint'(p.y2) - longint'(p.y1);
			adx = (dx < 0) ? -dx : dx;
			ady = (dy < 0) ? -dy : dy;
			rs = longint'(p.r1) + longint'(p.r2);
			e.touch = 0;
			e.same = 0;
			e.n1x = p.v1x; e.n1y = p.v1y; e.n2x = p.v2x; e.n2y = p.v2y;
			dd = 0;
			if (adx <= NEAR_LIM && ady <= NEAR_LIM) begin
				dd = adx * adx + ady * ady;
				e.touch = (dd <= rs * rs);
			end
			if (e.touch) begin
				if (dd == 0) begin
					e.same = 1;
				end else begin
					dot = (longint'(p.v2x) - longint'(p.v1x)) * dx
						+ (longint'(p.v2y) - longint'(p.v1y)) * dy;
					tx = along_share(dot, dx, dd);
					ty = along_share(dot, dy, dd);
					e.n1x = clip(longint'(p.v1x) + tx);
					e.n1y = clip(longint'(p.v1y) + ty);
					e.n2x = clip(longint'(p.v2x) - tx);
					e.n2y = clip(longint'(p.v2y) - ty);
				end
			end
			pending.push_back(e);
		endfunction

		function void field(string name, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				errors++;
				$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
			end
		endfunction

		// Check one delivered bounce against the oldest prediction.
		function void check(bounce_t got);
			bounce_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result expected none actual contact=%0d",
					$time, got.touch);
				return;
			end
			e = pending.pop_front();
			field("contact", e.touch, got.touch);
			field("coincident", e.same, got.same);
			field("new_first_vel_x", e.n1x, got.n1x);
			field("new_first_vel_y", e.n1y, got.n1y);
			field("new_second_vel_x", e.n2x, got.n2x);
			field("new_second_vel_y", e.n2y, got.n2y);
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [POS_W-1:0]        first_pos_x, first_pos_y, second_pos_x, second_pos_y;
	logic [RAD_W-1:0]        first_radius, second_radius;
	logic signed [VEL_W-1:0] first_vel_x, first_vel_y, second_vel_x, second_vel_y;
	logic                    out_valid;
	logic                    out_ready;
	logic                    contact, coincident;
	logic signed [VEL_W-1:0] new_first_vel_x, new_first_vel_y;
	logic signed [VEL_W-1:0] new_second_vel_x, new_second_vel_y;

	bounce_board board = new();
	int          tx_idle_pct;
	int          rx_idle_pct;
	longint      cycles;

	circle_pair_elastic_bounce i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.first_pos_x(first_pos_x), .first_pos_y(first_pos_y),
		.first_radius(first_radius),
		.first_vel_x(first_vel_x), .first_vel_y(first_vel_y),
		.second_pos_x(second_pos_x), .second_pos_y(second_pos_y),
		.second_radius(second_radius),
		.second_vel_x(second_vel_x), .second_vel_y(second_vel_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.contact(contact), .coincident(coincident),
		.new_first_vel_x(new_first_vel_x), .new_first_vel_y(new_first_vel_y),
		.new_second_vel_x(new_second_vel_x), .new_second_vel_y(new_second_vel_y)
	);

	// Run the clock.
	initial clk = 0;
	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Abort on a hung run.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Drive the receiver: a long hold-off first, then random stalls.
	initial begin
		int hold;
		out_ready = 0;
		@(posedge arst_n);
		for (hold = 0; hold < 300; hold++) @(posedge clk);
		forever begin
			@(posedge clk);
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Check each delivered bounce.
	always @(posedge clk) begin
		bounce_t got;
		if (arst_n && out_valid && out_ready) begin
			got.touch = contact;
			got.same = coincident;
			got.n1x = new_first_vel_x;
			got.n1y = new_first_vel_y;
			got.n2x = new_second_vel_x;
			got.n2y = new_second_vel_y;
			board.check(got);
		end
	end

	// Offer one request, idling beforehand at random, and hold it until taken.
	task automatic send(pair_t p);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1;
		first_pos_x <= p.x1; first_pos_y <= p.y1; first_radius <= p.r1;
		first_vel_x <= p.v1x; first_vel_y <= p.v1y;
		second_pos_x <= p.x2; second_pos_y <= p.y2; second_radius <= p.r2;
		second_vel_x <= p.v2x; second_vel_y <= p.v2y;
		do @(posedge clk); while (!in_ready);
		board.note(p);
	endtask

	function automatic pair_t make_pair(logic [POS_W-1:0] x1, logic [POS_W-1:0] y1,
		logic [RAD_W-1:0] r1, longint v1x, longint v1y,
		logic [POS_W-1:0] x2, logic [POS_W-1:0] y2,
		logic [RAD_W-1:0] r2, longint v2x, longint v2y);
		pair_t p;
		p.x1 = x1; p.y1 = y1; p.r1 = r1; p.v1x = v1x[15:0]; p.v1y = v1y[15:0];
		p.x2 = x2; p.y2 = y2; p.r2 = r2; p.v2x = v2x[15:0]; p.v2y = v2y[15:0];
		return p;
	endfunction

	function automatic logic signed [VEL_W-1:0] rand_vel();
		case ($urandom_range(7))
			0: return 0;
			1: return 16'sh7fff;
			2: return 16'sh8000;
			3: return $signed(16'($urandom_range(511))) - 16'sd256;
			default: return VEL_W'($urandom);
		endcase
	endfunction

	function automatic logic [POS_W-1:0] place(logic [POS_W-1:0] base, longint span);
		longint c;
		c = longint'(base) + $signed($urandom_range(2 * span)) - span;
		if (c < 0) c = 0;
		if (c > 1048575) c = 1048575;
		return c[POS_W-1:0];
	endfunction

	// Random pair: mostly close enough to touch, some coincident, some anywhere.
	function automatic pair_t rand_pair();
		pair_t p;
		longint span;
		p.x1 = POS_W'($urandom); p.y1 = POS_W'($urandom);
		p.r1 = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4095));
		p.r2 = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4095));
		p.v1x = rand_vel(); p.v1y = rand_vel(); p.v2x = rand_vel(); p.v2y = rand_vel();
		case ($urandom_range(19))
			0, 1, 2: begin
				p.x2 = POS_W'($urandom); p.y2 = POS_W'($urandom);
			end
			3: begin
				p.x2 = p.x1; p.y2 = p.y1;
			end
			default: begin
				span = longint'(p.r1) + longint'(p.r2) + 2;
				if ($urandom_range(1)) span = span / 2 + 1;
				p.x2 = place(p.x1, span);
				p.y2 = place(p.y1, span);
			end
		endcase
		return p;
	endfunction

	initial begin
		int n, ph;
		arst_n = 0;
		in_valid = 0;
		first_pos_x = 0; first_pos_y = 0; first_radius = 0;
		first_vel_x = 0; first_vel_y = 0;
		second_pos_x = 0; second_pos_y = 0; second_radius = 0;
		second_vel_x = 0; second_vel_y = 0;
		tx_idle_pct = 8;
		rx_idle_pct = 52;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, coincident centres, rest, far apart, saturation.
		send(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(make_pair(20'hfffff, 20'hfffff, 16'hffff, 32767, -32768,
			20'hfffff, 20'hfffff, 16'hffff, -32768, 32767));
		send(make_pair(0, 0, 16'hffff, 100, 0, 20'hfffff, 20'hfffff, 16'hffff, -5, 3));
		send(make_pair(0, 0, 16'hffff, 100, 0, 20'h20000, 0, 16'hffff, -5, 3));
		send(make_pair(0, 0, 16'hffff, 100, 0, 20'h20001, 0, 16'hffff, -5, 3));
		send(make_pair(1000, 1000, 256, 512, 0, 1512, 1000, 256, 0, 0));
		send(make_pair(1000, 1000, 256, 0, 0, 1512, 1000, 256, -512, 0));
		send(make_pair(1000, 1000, 256, 0, 0, 1513, 1000, 256, -512, 0));
		send(make_pair(500, 500, 10, 32767, 32767, 502, 501, 10, -32768, -32768));
		send(make_pair(500, 500, 10, -32768, -32768, 502, 501, 10, 32767, 32767));
		send(make_pair(500, 500, 10, 32767, -32768, 499, 502, 10, -32768, 32767));
		send(make_pair(4000, 4000, 300, 77, -91, 4200, 4300, 300, -13, 250));
		send(make_pair(4000, 4000, 300, 0, 0, 4200, 4300, 300, 0, 0));
		send(make_pair(20'h80000, 20'h7ffff, 16'h8000, 1, 2, 20'h7ffff, 20'h80000,
			16'h7fff, 3, 4));
		send(make_pair(20'h55555, 20'haaaaa, 16'h5555, 21845, -21846,
			20'haaaaa, 20'h55555, 16'haaaa, -21846, 21845));
		send(make_pair(7, 9, 3, 1, -1, 7, 12, 0, -1, 1));
		send(make_pair(7, 9, 0, 1, -1, 7, 9, 0, -1, 1));

		// Random pairs over three idling mixes.
		for (ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 52 : 0;
			rx_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 8 : 0;
			for (n = 0; n < 145; n++) send(rand_pair());
		end
		in_valid <= 0;

		// Drain, then allow for the pipeline depth.
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
